@@ hw/rtl/rdpd_pkg.sv @@
// Package for the rotary dial pulse decoder: payload structs, codes and constants.
// Used by rdpd_front, rdpd_fifo and rotary_dial_pulse_decoder_core; depends on nothing.
package rdpd_pkg;

  localparam int MAX_DIGITS_DEFAULT = 16;
  localparam int MAX_RESULTS        = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [6:0] IDLE_WRAP       = 7'd100;
  localparam logic [3:0] PULSE_MAX       = 4'd15;
  localparam logic [3:0] PULSES_FOR_ZERO = 4'd10;

  // Input opcodes.
  localparam logic [1:0] OP_HOOK    = 2'd0;
  localparam logic [1:0] OP_CONTACT = 2'd1;
  localparam logic [1:0] OP_PULSE   = 2'd2;
  localparam logic [1:0] OP_POLL    = 2'd3;

  // Result actions.
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_DIAL_TONE    = 3'd1;
  localparam logic [2:0] ACT_HANG_UP      = 3'd2;
  localparam logic [2:0] ACT_DIAL_START   = 3'd3;
  localparam logic [2:0] ACT_PULSE        = 3'd4;
  localparam logic [2:0] ACT_DIGIT_STORED = 3'd5;
  localparam logic [2:0] ACT_CALL_DIGIT   = 3'd6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HOOK_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_DEBOUNCE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIAL_IDLE_TICKS  = 2'd3;

  localparam logic [15:0] HOOK_DEBOUNCE_RESET    = 16'd100;
  localparam logic [15:0] CONTACT_DEBOUNCE_RESET = 16'd100;
  localparam logic [15:0] PULSE_DEBOUNCE_RESET   = 16'd100;
  localparam logic [6:0]  DIAL_IDLE_TICKS_RESET  = 7'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        hook_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] digit;
    logic [4:0] digit_count;
    logic       off_hook;
    logic       dropped;
    logic       last;
  } out_t;

endpackage

@@ hw/rtl/rdpd_front.sv @@
// Front part of the rotary dial pulse decoder: accepts events, debounces and
// classifies them, keeps all state and the digit store, and pushes results.
// Depends on rdpd_pkg.
module rdpd_front #(
  parameter int MAX_DIGITS = rdpd_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rdpd_pkg::in_t                  in_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rdpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output logic                           push,
  output rdpd_pkg::out_t                 push_data,
  input  logic                           fifo_full
);

  localparam int CAPACITY = (MAX_DIGITS < rdpd_pkg::MAX_RESULTS) ? MAX_DIGITS
                                                                  : rdpd_pkg::MAX_RESULTS;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t state, state_next;

  logic [15:0] hook_debounce_ms, contact_debounce_ms, pulse_debounce_ms;
  logic [6:0]  dial_idle_ticks;

  logic        hook_state, hook_state_next;
  logic        dial_active, dial_active_next;
  logic [3:0]  pulse_counter, pulse_counter_next;
  logic        call_placed, call_placed_next;
  logic [6:0]  idle_tick_counter, idle_tick_counter_next;
  logic [4:0]  stored_digits, stored_digits_next;
  logic [31:0] last_hook_time, last_hook_time_next;
  logic [31:0] last_contact_time, last_contact_time_next;
  logic [31:0] last_pulse_time, last_pulse_time_next;
  logic [4:0]  call_count, call_count_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;

  logic [3:0] digit_store [CAPACITY];
  logic [3:0] rd_data;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [3:0]       wr_data;

  logic        accept;
  logic [31:0] hook_gap, contact_gap, pulse_gap;
  logic        hook_ok, contact_ok, pulse_ok;
  logic        call_go;
  logic [6:0]  idle_tmp;
  logic [4:0]  sd_tmp;
  logic [3:0]  digit_val;
  logic        call_last;

  assign in_stall  = (state != S_IDLE) || fifo_full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Wrapping differences against each event class's last accepted time.
  assign hook_gap    = in_data.now_ms - last_hook_time;
  assign contact_gap = in_data.now_ms - last_contact_time;
  assign pulse_gap   = in_data.now_ms - last_pulse_time;
  assign hook_ok     = hook_gap > {16'd0, hook_debounce_ms};
  assign contact_ok  = contact_gap > {16'd0, contact_debounce_ms};
  assign pulse_ok    = pulse_gap > {16'd0, pulse_debounce_ms};

  assign call_last = ({{(5 - IDX_W){1'b0}}, rd_idx} + 5'd1) == call_count;

  always_comb begin
    state_next             = state;
    hook_state_next        = hook_state;
    dial_active_next       = dial_active;
    pulse_counter_next     = pulse_counter;
    call_placed_next       = call_placed;
    idle_tick_counter_next = idle_tick_counter;
    stored_digits_next     = stored_digits;
    last_hook_time_next    = last_hook_time;
    last_contact_time_next = last_contact_time;
    last_pulse_time_next   = last_pulse_time;
    call_count_next        = call_count;
    rd_idx_next            = rd_idx;
    wr_en                  = 1'b0;
    wr_addr                = stored_digits[IDX_W-1:0];
    wr_data                = 4'd0;
    call_go                = 1'b0;
    idle_tmp               = idle_tick_counter;
    sd_tmp                 = stored_digits;
    digit_val              = 4'd0;
    push                   = 1'b0;
    push_data              = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          push_data.action = rdpd_pkg::ACT_NONE;
          case (in_data.opcode)
            rdpd_pkg::OP_HOOK: begin
              if (hook_ok) begin
                if (in_data.hook_level && !hook_state) begin
                  hook_state_next  = 1'b1;
                  push_data.action = rdpd_pkg::ACT_DIAL_TONE;
                end else if (!in_data.hook_level && hook_state) begin
                  hook_state_next    = 1'b0;
                  call_placed_next   = 1'b0;
                  stored_digits_next = 5'd0;
                  push_data.action   = rdpd_pkg::ACT_HANG_UP;
                end
                last_hook_time_next = in_data.now_ms;
              end
            end
            rdpd_pkg::OP_CONTACT: begin
              if (contact_ok) begin
                if (hook_state && !dial_active) begin
                  dial_active_next       = 1'b1;
                  idle_tick_counter_next = 7'd0;
                  push_data.action       = rdpd_pkg::ACT_DIAL_START;
                end else if (hook_state) begin
                  push_data.action = rdpd_pkg::ACT_DIGIT_STORED;
                  if (pulse_counter > rdpd_pkg::PULSES_FOR_ZERO) begin
                    push_data.dropped = 1'b1;
                  end else begin
                    digit_val = (pulse_counter == rdpd_pkg::PULSES_FOR_ZERO) ? 4'd0
                                                                             : pulse_counter;
                    push_data.digit = digit_val;
                    if (stored_digits < 5'(CAPACITY)) begin
                      wr_en              = 1'b1;
                      wr_data            = digit_val;
                      stored_digits_next = stored_digits + 5'd1;
                    end else begin
                      push_data.dropped = 1'b1;
                    end
                  end
                  pulse_counter_next     = 4'd0;
                  dial_active_next       = 1'b0;
                  idle_tick_counter_next = 7'd0;
                end
                last_contact_time_next = in_data.now_ms;
              end
            end
            rdpd_pkg::OP_PULSE: begin
              if (hook_state && pulse_ok) begin
                if (pulse_counter < rdpd_pkg::PULSE_MAX) begin
                  pulse_counter_next = pulse_counter + 4'd1;
                end
                idle_tick_counter_next = 7'd0;
                push_data.action       = rdpd_pkg::ACT_PULSE;
                last_pulse_time_next   = in_data.now_ms;
              end
            end
            default: begin
              // Poll tick: maybe place the call, then advance the idle counter.
              if (hook_state && (stored_digits != 5'd0) &&
                  (idle_tick_counter >= dial_idle_ticks) && !call_placed) begin
                call_go          = 1'b1;
                call_placed_next = 1'b1;
                call_count_next  = stored_digits;
                sd_tmp           = 5'd0;
                rd_idx_next      = '0;
                state_next       = S_READ;
              end
              if (!hook_state) begin
                idle_tmp = 7'd0;
                sd_tmp   = 5'd0;
              end
              if (idle_tmp >= rdpd_pkg::IDLE_WRAP) begin
                idle_tmp = 7'd0;
              end
              idle_tick_counter_next = idle_tmp + 7'd1;
              stored_digits_next     = sd_tmp;
            end
          endcase
          push                  = !call_go;
          push_data.digit_count = stored_digits_next;
          push_data.off_hook    = hook_state_next;
          push_data.last        = 1'b1;
        end
      end
      S_READ: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (!fifo_full) begin
          push                  = 1'b1;
          push_data.action      = rdpd_pkg::ACT_CALL_DIGIT;
          push_data.digit       = rd_data;
          push_data.digit_count = stored_digits;
          push_data.off_hook    = hook_state;
          push_data.last        = call_last;
          if (call_last) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_store[wr_addr] <= wr_data;
    end
    if (state == S_READ) begin
      rd_data <= digit_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      hook_debounce_ms    <= rdpd_pkg::HOOK_DEBOUNCE_RESET;
      contact_debounce_ms <= rdpd_pkg::CONTACT_DEBOUNCE_RESET;
      pulse_debounce_ms   <= rdpd_pkg::PULSE_DEBOUNCE_RESET;
      dial_idle_ticks     <= rdpd_pkg::DIAL_IDLE_TICKS_RESET;
      hook_state          <= 1'b0;
      dial_active         <= 1'b0;
      pulse_counter       <= 4'd0;
      call_placed         <= 1'b0;
      idle_tick_counter   <= 7'd0;
      stored_digits       <= 5'd0;
      last_hook_time      <= 32'd0;
      last_contact_time   <= 32'd0;
      last_pulse_time     <= 32'd0;
      call_count          <= 5'd0;
      rd_idx              <= '0;
    end else begin
      state             <= state_next;
      hook_state        <= hook_state_next;
      dial_active       <= dial_active_next;
      pulse_counter     <= pulse_counter_next;
      call_placed       <= call_placed_next;
      idle_tick_counter <= idle_tick_counter_next;
      stored_digits     <= stored_digits_next;
      last_hook_time    <= last_hook_time_next;
      last_contact_time <= last_contact_time_next;
      last_pulse_time   <= last_pulse_time_next;
      call_count        <= call_count_next;
      rd_idx            <= rd_idx_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdpd_pkg::REG_HOOK_DEBOUNCE:    hook_debounce_ms    <= cfg_data;
          rdpd_pkg::REG_CONTACT_DEBOUNCE: contact_debounce_ms <= cfg_data;
          rdpd_pkg::REG_PULSE_DEBOUNCE:   pulse_debounce_ms   <= cfg_data;
          rdpd_pkg::REG_DIAL_IDLE_TICKS:  dial_idle_ticks     <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  a_stall_while_calling: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while a call is streaming");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("result pushed into a full queue");

  a_store_bounded: assert property (@(posedge clk) disable iff (rst)
    stored_digits <= 5'(CAPACITY))
    else $error("digit count beyond store capacity");

  a_idle_bounded: assert property (@(posedge clk) disable iff (rst)
    idle_tick_counter <= rdpd_pkg::IDLE_WRAP)
    else $error("idle tick counter out of range");

  a_call_empties_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && $past(state) == S_PUSH && !$past(rst)) |-> stored_digits == 5'd0)
    else $error("store not empty after a call");

endmodule

@@ hw/rtl/rdpd_fifo.sv @@
// Result queue of the rotary dial pulse decoder: a short FIFO whose head drives
// the output channel directly. Depends on rdpd_pkg.
module rdpd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rdpd_pkg::out_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output rdpd_pkg::out_t out_data
);

  localparam int DEPTH = rdpd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rdpd_pkg::out_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full      = count == CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(rd_ptr))
    else $error("stalled head moved");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

endmodule

@@ hw/rtl/rotary_dial_pulse_decoder_core.sv @@
// Rotary dial pulse decoder, top level: front part and result queue.
// Depends on rdpd_pkg, rdpd_front and rdpd_fifo.
//
// Events come in on the input channel (in_valid, in_stall, in_data): hook
// changes, dial contact edges, pulse edges and poll ticks, each with a
// millisecond timestamp. Results leave on the output channel (out_valid,
// out_stall, out_data). Registers are written on the cfg channel, which is
// always ready; writes belong to times when no event is in flight.
// An event is decoded in the cycle it is accepted; its result sits in a
// four-entry queue and shows at the output in the cycle after. Ordinary events
// are taken one per cycle while the queue is not full. A poll tick that places a
// call streams its N stored digits, each a read of the digit store followed by
// a push, so the front holds in_stall until the last digit has been pushed.
// When the receiver stalls, results pile up in the queue; once it is full
// the front stalls its input as well, and nothing is lost.
// Synchronous reset restores the register defaults, goes on hook, clears the
// counters and timestamps and empties the queue; the digit store holds no
// reset and is only read where it has been written.
module rotary_dial_pulse_decoder_core #(
  parameter int MAX_DIGITS = rdpd_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rdpd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rdpd_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rdpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic           push;
  rdpd_pkg::out_t push_data;
  logic           fifo_full;

  rdpd_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  rdpd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
